>>> design/abr_pkg.sv
// Package for the accelerating brightness ramp: widths, codes and the step table.
// It has no dependencies. Every other design file depends on it.
package abr_pkg;

  localparam int LEVEL_BITS = 16;
  localparam int LEVEL_W    = 16;
  localparam int PCT_IN_W   = 9;
  localparam int OFFSET_W   = 8;
  localparam int MAX_W      = 16;
  localparam int PCT_W      = 7;
  localparam int PSUM_W     = 10;
  localparam int PROD_W     = MAX_W + PCT_W;
  localparam int STEP_W     = 16;
  localparam int ALU_W      = ((LEVEL_BITS > STEP_W) ? LEVEL_BITS : STEP_W) + 2;
  localparam int STEP_LEN   = 60;
  localparam int N_W        = $clog2(STEP_LEN);
  localparam int STEP_LIMIT = STEP_LEN - 1;
  localparam int PCT_FULL   = 100;
  localparam int DIVISOR    = 100;
  localparam int MAX_RESET  = 255;

  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((2 ** RECIP_SHIFT + DIVISOR - 1) / DIVISOR);

  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  typedef enum logic {
    REG_PERCENT_OFFSET = 1'b0,
    REG_FULL_SCALE     = 1'b1
  } abr_reg_e;

  typedef struct packed {
    logic [OFFSET_W-1:0] percent_offset;
    logic [MAX_W-1:0]    full_scale;
  } abr_cfg_t;

  localparam logic [STEP_W-1:0] STEP_TABLE [STEP_LEN] = '{
    16'd1,     16'd1,     16'd1,     16'd2,     16'd2,
    16'd2,     16'd3,     16'd4,     16'd4,     16'd5,
    16'd6,     16'd7,     16'd9,     16'd11,    16'd13,
    16'd15,    16'd18,    16'd22,    16'd27,    16'd32,
    16'd38,    16'd46,    16'd55,    16'd66,    16'd79,
    16'd95,    16'd114,   16'd137,   16'd165,   16'd198,
    16'd237,   16'd285,   16'd342,   16'd410,   16'd492,
    16'd591,   16'd709,   16'd851,   16'd1021,  16'd1225,
    16'd1470,  16'd1764,  16'd2116,  16'd2540,  16'd3048,
    16'd3657,  16'd4389,  16'd5266,  16'd6320,  16'd7584,
    16'd9100,  16'd10921, 16'd13105, 16'd15726, 16'd18871,
    16'd22645, 16'd27174, 16'd32609, 16'd39130, 16'd46956
  };

endpackage

>>> design/abr_if.sv
// Valid/ready channel interfaces for requests and ramp steps.
// Depends on abr_pkg for the field widths.
interface abr_in_if;
  logic                            valid;
  logic                            ready;
  logic [abr_pkg::PCT_IN_W-1:0]    target_percent;

  modport source (output valid, output target_percent, input ready);
  modport sink (input valid, input target_percent, output ready);
endinterface

interface abr_out_if;
  logic                         valid;
  logic                         ready;
  logic [abr_pkg::LEVEL_W-1:0]  level;
  logic                         last_step;

  modport source (output valid, output level, output last_step, input ready);
  modport sink (input valid, input level, input last_step, output ready);
endinterface

>>> design/abr_regs.sv
// APB-style configuration registers of the brightness ramp.
// Depends on abr_pkg for the register codes and the configuration struct.
module abr_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [abr_pkg::ADDR_W-1:0]  paddr,
  input  logic [abr_pkg::DATA_W-1:0]  pwdata,
  output logic [abr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output abr_pkg::abr_cfg_t           cfg_o
);
  import abr_pkg::*;

  abr_cfg_t cfg_q;
  abr_reg_e reg_sel;
  logic     wr_en;

  assign reg_sel = abr_reg_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.percent_offset <= '0;
      cfg_q.full_scale     <= MAX_W'(MAX_RESET);
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PERCENT_OFFSET: cfg_q.percent_offset <= pwdata[OFFSET_W-1:0];
        REG_FULL_SCALE:     cfg_q.full_scale     <= pwdata[MAX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PERCENT_OFFSET: prdata = DATA_W'(cfg_q.percent_offset);
      REG_FULL_SCALE:     prdata = DATA_W'(cfg_q.full_scale);
      default:            prdata = '0;
    endcase
  end

endmodule

>>> design/accelerating_brightness_ramp_core.sv
// Top level of the accelerating brightness ramp: sequencer around one shared adder.
// Depends on abr_pkg, the channel interfaces in abr_if and the registers in abr_regs.
//
// A request beat on in_i carries a signed percent. The offset register is added,
// the sum is clamped to 0..100 and scaled by full_scale / 100. The block then
// walks from its current level toward that target with growing steps and sends
// each step as a beat on out_o, and finally the target itself with last_step set.
// The target becomes the current level for the next request.
// After the accept cycle a request passes a multiply state, a state that divides
// by 100 through a reciprocal multiply and a setup state, then sends one output
// beat per cycle while the receiver does not stall, at most 60 beats. in_i.ready is
// high only between requests and rises when the final beat is loaded.
// One output register holds the beat in flight; while the receiver stalls, the ramp
// waits. Reset sets the current level and the offset to zero and full_scale to 255.
// The user writes registers through the APB port while idle; the block never checks.
module accelerating_brightness_ramp_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  abr_in_if.sink                      in_i,
  abr_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [abr_pkg::ADDR_W-1:0]  paddr,
  input  logic [abr_pkg::DATA_W-1:0]  pwdata,
  output logic [abr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import abr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SETUP,
    ST_STEP
  } state_e;

  abr_cfg_t cfg;

  state_e                state_q;
  logic [PCT_W-1:0]      pct_q;
  logic [PROD_W-1:0]     dq_q;
  logic [LEVEL_BITS-1:0] cur_q;
  logic [LEVEL_BITS-1:0] target_q;
  logic                  up_q;
  logic [N_W-1:0]        n_q;
  logic                  out_valid_q;
  logic [LEVEL_W-1:0]    level_q;
  logic                  last_q;

  logic signed [PSUM_W-1:0]    pct_sum;
  logic [PCT_W-1:0]            pct_clamp;
  logic [PROD_W+RECIP_W-1:0]   recip_prod;
  logic [ALU_W-1:0]            alu_a;
  logic [ALU_W-1:0]            alu_b;
  logic                        alu_sub;
  logic [ALU_W-1:0]            alu_y;
  logic [ALU_W-1:0]            target_ext;
  logic                        overshoot;
  logic                        slot_free;

  abr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  always_comb begin
    pct_sum = PSUM_W'($signed(in_i.target_percent)) + PSUM_W'($signed(cfg.percent_offset));
    if (pct_sum < 0) begin
      pct_clamp = '0;
    end else if (pct_sum > PSUM_W'(PCT_FULL)) begin
      pct_clamp = PCT_W'(PCT_FULL);
    end else begin
      pct_clamp = pct_sum[PCT_W-1:0];
    end
  end

  assign recip_prod = (PROD_W+RECIP_W)'(dq_q) * (PROD_W+RECIP_W)'(RECIP);

  always_comb begin
    target_ext = ALU_W'(target_q);
    alu_a      = ALU_W'(cur_q);
    alu_b      = ALU_W'(STEP_TABLE[n_q]);
    alu_sub    = !up_q;
    alu_y      = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    if (up_q) begin
      overshoot = $signed(alu_y) > $signed(target_ext);
    end else begin
      overshoot = $signed(alu_y) < $signed(target_ext);
    end
  end

  assign slot_free = !out_valid_q || out_o.ready;

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.level     = level_q;
  assign out_o.last_step = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pct_q       <= '0;
      dq_q        <= '0;
      cur_q       <= '0;
      target_q    <= '0;
      up_q        <= 1'b0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
      level_q     <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != ST_STEP)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            pct_q   <= pct_clamp;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          dq_q    <= PROD_W'(cfg.full_scale) * PROD_W'(pct_q);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          dq_q    <= PROD_W'(recip_prod >> RECIP_SHIFT);
          state_q <= ST_SETUP;
        end
        ST_SETUP: begin
          target_q <= dq_q[LEVEL_BITS-1:0];
          up_q     <= dq_q[LEVEL_BITS-1:0] >= cur_q;
          n_q      <= '0;
          state_q  <= ST_STEP;
        end
        ST_STEP: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            if ((n_q == N_W'(STEP_LIMIT)) || overshoot) begin
              level_q <= LEVEL_W'(target_q);
              last_q  <= 1'b1;
              cur_q   <= target_q;
              state_q <= ST_IDLE;
            end else begin
              level_q <= LEVEL_W'(alu_y[LEVEL_BITS-1:0]);
              last_q  <= 1'b0;
              cur_q   <= alu_y[LEVEL_BITS-1:0];
              n_q     <= n_q + N_W'(1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> design/abr_checker.sv
// Port-level checker for the brightness ramp and the bind that attaches it.
// Depends on abr_pkg for widths and on accelerating_brightness_ramp_core.
module abr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [abr_pkg::LEVEL_W-1:0] out_level_i,
  input logic                        out_last_i
);
  import abr_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_level_i) && $stable(out_last_i))
    else $error("Stalled output beat changed.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("Request accepted while a ramp was in progress.");

  a_idle_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i && out_valid_i |-> out_last_i)
    else $error("Block idle while an intermediate step is pending.");

  a_known_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !$isunknown({out_level_i, out_last_i}))
    else $error("Output beat carries unknown bits.");

endmodule

bind accelerating_brightness_ramp_core abr_checker u_abr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_level_i (out_o.level),
  .out_last_i  (out_o.last_step)
);
